FILE: rtl/sdc_pkg.sv
package sdc_pkg;

  // Fixed item geometry
  localparam int NUM_ACQ      = 4;
  localparam int SAMPLE_BITS  = 16;
  localparam int SLICE_VOXELS = 4096;
  localparam int IDX_W        = 12;
  localparam int SUM_W        = 28;
  localparam int CNT_W        = 13;
  localparam int PCT_W        = 7;
  localparam int ATT_W        = 17;

  // Shared multiplier geometry
  localparam int MUL_A_W = 35;
  localparam int MUL_B_W = 17;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  // Opcodes
  localparam logic [1:0] OP_LOAD = 2'd0;
  localparam logic [1:0] OP_EVAL = 2'd1;
  localparam logic [1:0] OP_READ = 2'd2;
  localparam logic [1:0] OP_NOP  = 2'd3;

  // Configuration register indexes
  localparam logic CFG_THRESH = 1'b0;
  localparam logic CFG_ATTEN  = 1'b1;

  localparam logic [ATT_W-1:0]   ATTEN_RESET = 17'h10000;
  localparam logic [NUM_ACQ-1:0] ALL_KEEP    = '1;

  typedef struct packed {
    logic [1:0]             opcode;
    logic [IDX_W-1:0]       voxel_index;
    logic                   in_mask;
    logic [SAMPLE_BITS-1:0] ref_value;
    logic [SAMPLE_BITS-1:0] sample_a;
    logic [SAMPLE_BITS-1:0] sample_b;
    logic [SAMPLE_BITS-1:0] sample_c;
    logic [SAMPLE_BITS-1:0] sample_d;
  } sdc_in_t;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] out_a;
    logic [SAMPLE_BITS-1:0] out_b;
    logic [SAMPLE_BITS-1:0] out_c;
    logic [SAMPLE_BITS-1:0] out_d;
    logic [NUM_ACQ-1:0]     reject_mask;
    logic                   all_failed;
    logic                   empty_slice;
  } sdc_out_t;

  // Saturating accumulate for the slice sums
  function automatic logic [SUM_W-1:0] sat_add_sum(logic [SUM_W-1:0] a,
                                                    logic [SUM_W-1:0] b);
    logic [SUM_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[SUM_W] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
  endfunction

endpackage

FILE: rtl/slice_dropout_correct_unit.sv
// The unit takes one beat at a time: in_stall is high until the result is
// registered and the sequencer is back in idle, and a result held by
// out_stall keeps it busy. Evaluate is stepped through the single 35x17
// multiplier, reused for the threshold product and each acquisition; a read
// passes the sample memory port and uses the multiplier for a divide by three.
// Synchronous active-low reset clears control, sums, status, the configuration registers and output valid.
module slice_dropout_correct_unit #(
  parameter int SLICE_VOXELS = sdc_pkg::SLICE_VOXELS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  sdc_pkg::sdc_in_t              in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output sdc_pkg::sdc_out_t             out_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic                          cfg_index,
  input  logic [sdc_pkg::ATT_W-1:0]     cfg_data
);
  import sdc_pkg::*;

  localparam int AW = (SLICE_VOXELS > 1) ? $clog2(SLICE_VOXELS) : 1;
  localparam int MW = NUM_ACQ * SAMPLE_BITS;
  localparam int TOT_W = SAMPLE_BITS + 2;
  localparam logic [MUL_B_W-1:0] RECIP3 = 17'd87381;  // floor(2^18 / 3)
  localparam logic [MUL_B_W-1:0] PCT100 = 17'd100;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_LOAD = 3'd1;
  localparam logic [2:0] ST_EVAL = 3'd2;
  localparam logic [2:0] ST_RMEM = 3'd3;
  localparam logic [2:0] ST_RSUM = 3'd4;
  localparam logic [2:0] ST_RMUL = 3'd5;
  localparam logic [2:0] ST_RFIN = 3'd6;
  localparam logic [2:0] ST_RESP = 3'd7;

  logic [2:0]             state_r;
  logic [2:0]             step_r;
  sdc_in_t                item_r;
  logic [PCT_W-1:0]       pct_r;
  logic [ATT_W-1:0]       atten_r;
  logic [SUM_W-1:0]       acq_sum_r [NUM_ACQ];
  logic [SUM_W-1:0]       ref_sum_r;
  logic [CNT_W-1:0]       count_r;
  logic [NUM_ACQ-1:0]     keep_r;
  logic [NUM_ACQ-1:0]     keep_acc_r;
  logic [1:0]             status_r;
  logic [MUL_P_W-1:0]     prod_r;
  logic [MUL_P_W-1:0]     rhs_r;
  logic [TOT_W-1:0]       total_r;
  logic [2:0]             kept_r;
  logic [MW-1:0]          res_samp_r;
  logic [MW-1:0]          rd_data_r;
  logic                   out_valid_r;
  sdc_out_t               out_data_r;

  logic [MW-1:0]          mem [SLICE_VOXELS];
  logic [AW-1:0]          addr;
  logic                   in_range;
  logic                   mem_we;
  logic [MW-1:0]          wdata;

  logic [MUL_A_W-1:0]     mul_a;
  logic [MUL_B_W-1:0]     mul_b;
  logic [MUL_P_W-1:0]     mul_p;
  logic [1:0]             mul_lane;
  logic [1:0]             cmp_lane;
  logic                   cmp_gt;
  logic                   out_free;
  logic                   in_acc;
  logic [NUM_ACQ-1:0]     keep_fin;

  logic [TOT_W-1:0]       total_c;
  logic [2:0]             kept_c;
  logic [TOT_W-1:0]       q0;
  logic [TOT_W+1:0]       rem;
  logic [TOT_W-1:0]       q3;
  logic [TOT_W-1:0]       fill;
  logic [MW-1:0]          rd_out;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Item address decode
  assign addr     = AW'(item_r.voxel_index);
  assign in_range = (32'(item_r.voxel_index) < SLICE_VOXELS);
  assign wdata    = {item_r.sample_d, item_r.sample_c, item_r.sample_b, item_r.sample_a};
  assign mem_we   = (state_r == ST_LOAD) && in_range;

  // Sample store: one write port, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[addr] <= wdata;
    end
    rd_data_r <= mem[addr];
  end

  // Shared multiplier operand select
  assign mul_lane = 2'(step_r - 3'd2);
  assign cmp_lane = 2'(step_r - 3'd3);
  always_comb begin
    mul_a = '0;
    mul_b = PCT100;
    if (state_r == ST_RMUL) begin
      mul_a = MUL_A_W'(total_r);
      mul_b = RECIP3;
    end else if (step_r == 3'd0) begin
      mul_a = MUL_A_W'(ref_sum_r);
      mul_b = MUL_B_W'(pct_r);
    end else if (step_r == 3'd1) begin
      mul_a = prod_r[MUL_A_W-1:0];
      mul_b = atten_r;
    end else begin
      mul_a = MUL_A_W'(acq_sum_r[mul_lane]);
    end
  end
  assign mul_p  = MUL_P_W'(mul_a) * MUL_P_W'(mul_b);
  // acq*100*65536 against ref*pct*atten
  assign cmp_gt = MUL_P_W'({prod_r[MUL_A_W-1:0], 16'h0}) > rhs_r;
  assign keep_fin = keep_acc_r | (NUM_ACQ'(cmp_gt) << cmp_lane);

  // Kept-lane total for a read
  always_comb begin
    total_c = '0;
    kept_c  = '0;
    for (int i = 0; i < NUM_ACQ; i++) begin
      if (keep_r[i]) begin
        total_c = total_c + TOT_W'(rd_data_r[i*SAMPLE_BITS +: SAMPLE_BITS]);
        kept_c  = kept_c + 3'd1;
      end
    end
  end

  // Fill value: shifts for 1, 2, 4 kept; reciprocal with one correction for 3
  assign q0  = prod_r[18 +: TOT_W];
  assign rem = (TOT_W+2)'(total_r) - (TOT_W+2)'(q0) * (TOT_W+2)'(3);
  assign q3  = (rem >= (TOT_W+2)'(3)) ? q0 + TOT_W'(1) : q0;
  always_comb begin
    case (kept_r)
      3'd1:    fill = total_r;
      3'd2:    fill = total_r >> 1;
      3'd3:    fill = q3;
      3'd4:    fill = total_r >> 2;
      default: fill = '0;
    endcase
  end
  always_comb begin
    for (int i = 0; i < NUM_ACQ; i++) begin
      rd_out[i*SAMPLE_BITS +: SAMPLE_BITS] = keep_r[i]
        ? rd_data_r[i*SAMPLE_BITS +: SAMPLE_BITS] : fill[SAMPLE_BITS-1:0];
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pct_r   <= '0;
      atten_r <= ATTEN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_THRESH: pct_r   <= cfg_data[PCT_W-1:0];
        CFG_ATTEN:  atten_r <= cfg_data;
        default:    ;
      endcase
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      step_r     <= '0;
      ref_sum_r  <= '0;
      count_r    <= '0;
      keep_r     <= ALL_KEEP;
      keep_acc_r <= '0;
      status_r   <= '0;
      for (int i = 0; i < NUM_ACQ; i++) acq_sum_r[i] <= '0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            item_r     <= in_data;
            step_r     <= '0;
            keep_acc_r <= '0;
            res_samp_r <= '0;
            unique case (in_data.opcode)
              OP_LOAD: state_r <= ST_LOAD;
              OP_EVAL: state_r <= ST_EVAL;
              OP_READ: state_r <= ST_RMEM;
              OP_NOP:  state_r <= ST_RESP;
              default: state_r <= ST_RESP;
            endcase
          end
        end
        ST_LOAD: begin
          if (in_range && item_r.in_mask) begin
            count_r   <= (count_r == '1) ? count_r : count_r + CNT_W'(1);
            ref_sum_r <= sat_add_sum(ref_sum_r, SUM_W'(item_r.ref_value));
            for (int i = 0; i < NUM_ACQ; i++) begin
              acq_sum_r[i] <= sat_add_sum(acq_sum_r[i],
                                          SUM_W'(wdata[i*SAMPLE_BITS +: SAMPLE_BITS]));
            end
          end
          state_r <= ST_RESP;
        end
        ST_EVAL: begin
          step_r <= step_r + 3'd1;
          if (step_r == 3'd1) begin
            rhs_r <= mul_p;
          end else begin
            prod_r <= mul_p;
          end
          if (step_r >= 3'd3) begin
            keep_acc_r <= keep_fin;
          end
          if (step_r == 3'd6) begin
            if (count_r == '0) begin
              keep_r   <= ALL_KEEP;
              status_r <= 2'b10;
            end else if (keep_fin == '0) begin
              keep_r   <= ALL_KEEP;
              status_r <= 2'b01;
            end else begin
              keep_r   <= keep_fin;
              status_r <= 2'b00;
            end
            ref_sum_r <= '0;
            count_r   <= '0;
            for (int i = 0; i < NUM_ACQ; i++) acq_sum_r[i] <= '0;
            state_r <= ST_RESP;
          end
        end
        ST_RMEM: state_r <= ST_RSUM;
        ST_RSUM: begin
          total_r <= total_c;
          kept_r  <= kept_c;
          state_r <= ST_RMUL;
        end
        ST_RMUL: begin
          prod_r  <= mul_p;
          state_r <= ST_RFIN;
        end
        ST_RFIN: begin
          res_samp_r <= in_range ? rd_out : '0;
          state_r    <= ST_RESP;
        end
        ST_RESP: begin
          if (out_free) state_r <= ST_IDLE;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_RESP && out_free) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_RESP && out_free) begin
      out_data_r.out_a       <= res_samp_r[0*SAMPLE_BITS +: SAMPLE_BITS];
      out_data_r.out_b       <= res_samp_r[1*SAMPLE_BITS +: SAMPLE_BITS];
      out_data_r.out_c       <= res_samp_r[2*SAMPLE_BITS +: SAMPLE_BITS];
      out_data_r.out_d       <= res_samp_r[3*SAMPLE_BITS +: SAMPLE_BITS];
      out_data_r.reject_mask <= status_r[1] ? '0 : (status_r[0] ? ALL_KEEP : ~keep_r);
      out_data_r.all_failed  <= status_r[0];
      out_data_r.empty_slice <= status_r[1];
    end
  end

endmodule

FILE: rtl/sdc_checker.sv
module sdc_port_props (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input sdc_pkg::sdc_out_t out_data
);
  import sdc_pkg::*;

  // A stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result beat changed");

  // One item at a time: busy right after an accepted beat
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while busy");

  // Status flags are exclusive
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.all_failed && out_data.empty_slice))
    else $error("all_failed and empty_slice both set");

  a_empty_rej: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.empty_slice |-> out_data.reject_mask == '0)
    else $error("empty slice with rejects");

  a_fail_rej: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.all_failed |-> out_data.reject_mask == ALL_KEEP)
    else $error("all failed without full reject mask");

endmodule

bind slice_dropout_correct_unit sdc_port_props u_sdc_port_props (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

FILE: verif/sdc_checker.sv
module sdc_checker
  import sdc_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_stall,
  input  sdc_in_t  in_data,
  input  logic     out_valid,
  input  logic     out_stall,
  input  sdc_out_t out_data,
  input  logic     cfg_valid,
  input  logic     cfg_ready,
  input  logic     cfg_index,
  input  logic [ATT_W-1:0] cfg_data,
  output int       fail_count,
  output int       pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [SUM_W-1:0] SUM_SAT = '1;
  localparam logic [CNT_W-1:0] CNT_SAT = '1;

  // shadow state of the slice
  logic [PCT_W-1:0]       thr_pct;
  logic [ATT_W-1:0]       atten;
  logic [SAMPLE_BITS-1:0] voxel_mem [SLICE_VOXELS][NUM_ACQ];
  logic [SUM_W-1:0]       acq_acc [NUM_ACQ];
  logic [SUM_W-1:0]       ref_acc;
  logic [CNT_W-1:0]       mask_cnt;
  logic [NUM_ACQ-1:0]     kept;
  logic                   st_failed, st_empty;

  sdc_out_t corrected_q[$];

  assign pending = corrected_q.size();

  function automatic logic [SUM_W-1:0] acc_sat(logic [SUM_W-1:0] a, logic [SUM_W-1:0] b);
    logic [SUM_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[SUM_W] ? SUM_SAT : s[SUM_W-1:0];
  endfunction

  // advance the shadow state by one beat and return the expected result
  function automatic sdc_out_t correct_voxel(sdc_in_t b);
    sdc_out_t r;
    logic [SAMPLE_BITS-1:0] s [NUM_ACQ];
    logic [63:0] rhs, lhs;
    logic [NUM_ACQ-1:0] k;
    int unsigned total, nk, fill;
    r = '0;
    s[0] = b.sample_a; s[1] = b.sample_b; s[2] = b.sample_c; s[3] = b.sample_d;
    case (b.opcode)
      OP_LOAD: begin
        for (int i = 0; i < NUM_ACQ; i++) voxel_mem[b.voxel_index][i] = s[i];
        if (b.in_mask) begin
          if (mask_cnt != CNT_SAT) mask_cnt = mask_cnt + CNT_W'(1);
          ref_acc = acc_sat(ref_acc, SUM_W'(b.ref_value));
          for (int i = 0; i < NUM_ACQ; i++) acq_acc[i] = acc_sat(acq_acc[i], SUM_W'(s[i]));
        end
      end
      OP_EVAL: begin
        if (mask_cnt == 0) begin
          kept = ALL_KEEP; st_empty = 1; st_failed = 0;
        end else begin
          rhs = 64'(ref_acc) * 64'(atten) * 64'(thr_pct);
          k = '0;
          for (int i = 0; i < NUM_ACQ; i++) begin
            lhs = 64'(acq_acc[i]) * 64'd6553600;
            if (lhs > rhs) k[i] = 1'b1;
          end
          st_empty = 0;
          st_failed = (k == '0);
          kept = st_failed ? ALL_KEEP : k;
        end
        for (int i = 0; i < NUM_ACQ; i++) acq_acc[i] = '0;
        ref_acc = '0;
        mask_cnt = '0;
      end
      OP_READ: begin
        total = 0; nk = 0;
        for (int i = 0; i < NUM_ACQ; i++)
          if (kept[i]) begin
            total += voxel_mem[b.voxel_index][i];
            nk++;
          end
        fill = nk ? total / nk : 0;
        for (int i = 0; i < NUM_ACQ; i++)
          s[i] = kept[i] ? voxel_mem[b.voxel_index][i] : SAMPLE_BITS'(fill);
        r.out_a = s[0]; r.out_b = s[1]; r.out_c = s[2]; r.out_d = s[3];
      end
      default: ;
    endcase
    r.reject_mask = st_empty ? '0 : (st_failed ? ALL_KEEP : ~kept);
    r.all_failed  = st_failed;
    r.empty_slice = st_empty;
    return r;
  endfunction

  // watch the three channels
  always @(posedge clk) begin
    sdc_out_t e;
    if (!rst_n) begin
      thr_pct = '0; atten = ATTEN_RESET; ref_acc = '0; mask_cnt = '0;
      for (int i = 0; i < NUM_ACQ; i++) acq_acc[i] = '0;
      kept = ALL_KEEP; st_failed = 0; st_empty = 0;
      corrected_q.delete();
      fail_count = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_THRESH) thr_pct = cfg_data[PCT_W-1:0];
        else atten = cfg_data;
      end
      if (out_valid && !out_stall) begin
        if (corrected_q.size() == 0) begin
          $error("unexpected result beat");
          fail_count = fail_count + 1;
        end else begin
          e = corrected_q.pop_front();
          if (out_data.out_a !== e.out_a) begin
            $error("out_a exp %0d got %0d", e.out_a, out_data.out_a); fail_count++; end
          if (out_data.out_b !== e.out_b) begin
            $error("out_b exp %0d got %0d", e.out_b, out_data.out_b); fail_count++; end
          if (out_data.out_c !== e.out_c) begin
            $error("out_c exp %0d got %0d", e.out_c, out_data.out_c); fail_count++; end
          if (out_data.out_d !== e.out_d) begin
            $error("out_d exp %0d got %0d", e.out_d, out_data.out_d); fail_count++; end
          if (out_data.reject_mask !== e.reject_mask) begin
            $error("reject_mask exp %0h got %0h", e.reject_mask, out_data.reject_mask);
            fail_count++;
          end
          if (out_data.all_failed !== e.all_failed) begin
            $error("all_failed exp %0b got %0b", e.all_failed, out_data.all_failed);
            fail_count++;
          end
          if (out_data.empty_slice !== e.empty_slice) begin
            $error("empty_slice exp %0b got %0b", e.empty_slice, out_data.empty_slice);
            fail_count++;
          end
        end
      end
      if (in_valid && !in_stall) corrected_q = {corrected_q, correct_voxel(in_data)};
    end
  end
endmodule

FILE: verif/tb_top.sv
module tb_top;
  import sdc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0, in_stall, out_valid, out_stall = 0;
  sdc_in_t in_data = '0;
  sdc_out_t out_data;
  logic cfg_valid = 0, cfg_ready, cfg_index = 0;
  logic [ATT_W-1:0] cfg_data = '0;
  int fail_count, pending;
  int cycles = 0;
  int stall_left = 0;
  bit stim_done = 0;
  int idx_pool [$];

  always #4 clk = ~clk;

  slice_dropout_correct_unit dut (.*);
  sdc_checker chk (.*);

  // cycle limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // receiver stall: runs of random length, mostly short, a few long
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 99) < 40) begin
      out_stall  <= 1;
      stall_left <= gap_len();
    end else begin
      out_stall <= 0;
    end
  end

  // called at a falling edge; in_stall only moves at the rising edge
  task automatic send(sdc_in_t b);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid <= 0;
      repeat (g) @(negedge clk);
    end
    in_data <= b;
    in_valid <= 1;
    while (in_stall) @(negedge clk);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (pending != 0) @(negedge clk);
    repeat (12) @(negedge clk);
  endtask

  task automatic write_reg(logic idx, logic [ATT_W-1:0] v);
    cfg_index <= idx;
    cfg_data <= v;
    cfg_valid <= 1;
    while (!cfg_ready) @(negedge clk);
    @(negedge clk);
    cfg_valid <= 0;
    @(negedge clk);
  endtask

  function automatic sdc_in_t load_beat(logic [IDX_W-1:0] idx, logic m);
    sdc_in_t b;
    b = '0;
    b.opcode = OP_LOAD; b.voxel_index = idx; b.in_mask = m;
    b.ref_value = SAMPLE_BITS'($urandom); b.sample_a = SAMPLE_BITS'($urandom);
    b.sample_b = SAMPLE_BITS'($urandom);
    b.sample_c = SAMPLE_BITS'($urandom); b.sample_d = SAMPLE_BITS'($urandom);
    return b;
  endfunction

  function automatic sdc_in_t ctl_beat(logic [1:0] op, logic [IDX_W-1:0] idx);
    sdc_in_t b;
    b = '0;
    b.opcode = op; b.voxel_index = idx;
    b.ref_value = SAMPLE_BITS'($urandom); b.sample_a = SAMPLE_BITS'($urandom);
    return b;
  endfunction

  // one slice: loads with random content, an evaluate, reads of loaded voxels; if noisy, stray nops and evaluates
  task automatic run_slice(int nload, bit noisy);
    sdc_in_t b;
    logic [IDX_W-1:0] idx;
    int scale;
    idx_pool.delete();
    scale = $urandom_range(0, 3);
    for (int i = 0; i < nload; i++) begin
      idx = IDX_W'($urandom);
      b = load_beat(idx, $urandom_range(0, 4) != 0);
      // sometimes one acquisition is dim so it drops out
      if (scale == 1) b.sample_b = b.sample_b >> 4;
      if (scale == 2) b.ref_value = b.ref_value >> 2;
      send(b);
      idx_pool = {idx_pool, int'(idx)};
      if (noisy && $urandom_range(0, 9) == 0) send(ctl_beat(OP_NOP, IDX_W'($urandom)));
    end
    send(ctl_beat(OP_EVAL, IDX_W'($urandom)));
    for (int i = 0; i < nload; i++) begin
      send(ctl_beat(OP_READ, IDX_W'(idx_pool[$urandom_range(0, idx_pool.size() - 1)])));
      if (noisy && $urandom_range(0, 9) == 0) send(ctl_beat(OP_EVAL, 12'd0));
    end
  endtask

  initial begin
    sdc_in_t b;
    int items;
    repeat (9) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);

    // directed: reset settings, read before any evaluate, empty slice, nop
    b = load_beat(12'd0, 1'b1);
    b.ref_value = '1; b.sample_a = '1; b.sample_b = '0; b.sample_c = '1;
    b.sample_d = 16'd1;
    send(b);
    send(ctl_beat(OP_READ, 12'd0));
    send(ctl_beat(OP_NOP, 12'hfff));
    send(ctl_beat(OP_EVAL, 12'd0));
    send(ctl_beat(OP_READ, 12'd0));
    send(ctl_beat(OP_EVAL, 12'd0));          // empty slice
    send(ctl_beat(OP_READ, 12'd0));
    b = load_beat(12'hfff, 1'b0);
    send(b);
    send(ctl_beat(OP_READ, 12'hfff));
    drain();
    // threshold 100 at full attenuation: every acquisition fails when equal
    write_reg(CFG_THRESH, 17'd100);
    write_reg(CFG_ATTEN, 17'h10000);
    b = load_beat(12'd5, 1'b1);
    b.ref_value = 16'd1000; b.sample_a = 16'd1000; b.sample_b = 16'd1000;
    b.sample_c = 16'd1000; b.sample_d = 16'd1000;
    send(b);
    send(ctl_beat(OP_EVAL, 12'd0));
    send(ctl_beat(OP_READ, 12'd5));
    b.sample_a = 16'd1001; b.sample_c = 16'd3;
    send(b);
    send(ctl_beat(OP_EVAL, 12'd0));
    send(ctl_beat(OP_READ, 12'd5));
    drain();
    // zero attenuation keeps everything above zero
    write_reg(CFG_ATTEN, 17'd0);
    write_reg(CFG_THRESH, 17'd127);
    b.sample_b = 16'd0;
    send(b);
    send(ctl_beat(OP_EVAL, 12'd0));
    send(ctl_beat(OP_READ, 12'd5));
    drain();

    // random phases over several settings
    items = 0;
    while (items < 950) begin
      case ($urandom_range(0, 3))
        0: write_reg(CFG_THRESH, ATT_W'($urandom_range(0, 100)));
        1: write_reg(CFG_ATTEN, ATT_W'($urandom_range(0, 65536)));
        2: write_reg(CFG_THRESH, $urandom_range(0, 1) ? 17'd0 : 17'd100);
        default: write_reg(CFG_ATTEN, $urandom_range(0, 1) ? 17'd0 : 17'h10000);
      endcase
      for (int s = 0; s < 4; s++) begin
        int n;
        n = $urandom_range(1, 12);
        run_slice(n, $urandom_range(0, 2) == 0);
        items += 2 * n + 1;
      end
      drain();
    end
    stim_done = 1;
  end

  // verdict
  initial begin
    wait (stim_done);
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (fail_count == 0) $display("tb_top: done, clean");
    else $display("tb_top: done, errors");
    $finish;
  end
endmodule
